[design/ertm_pkg.sv]
// ----------------------------------------------------------------------------
// ertm_pkg
// shared constants, types and the cordic arctangent table for the euler unit
// ----------------------------------------------------------------------------
package ertm_pkg;

   localparam int ANGLE_BITS        = 16;
   localparam int OUT_FRACTION_BITS = 14;
   localparam int CORDIC_STAGES     = 16;

   // iterations actually built (table lists 31 entries, zero beyond)
   localparam int CORDIC_N    = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int FIELD_W     = 16;
   localparam int WORK_FRAC   = 30;
   localparam int VAL_W       = 34;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int CORDIC_PIPE = CORDIC_N + 2;
   localparam int PROD_STAGES = 5;
   localparam int NUM_STAGES  = CORDIC_PIPE + PROD_STAGES;
   localparam int NUM_ELEM    = 9;

   typedef logic signed [VAL_W-1:0]  val_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic [FIELD_W-1:0]       field_type;

   typedef struct packed {
      val_type s;
      val_type c;
   } sincos_type;

   localparam val_type CORDIC_GAIN  = 34'sd652032874;
   localparam val_type QUARTER_TURN = 34'sd1073741824;
   localparam val_type HALF_TURN    = 34'sd2147483648;

   // atan(2^-i) in units of 2^-32 turn
   function automatic val_type atan_of(input int idx);
      val_type t;
      case (idx)
         0:  t = 34'sd536870912;
         1:  t = 34'sd316933406;
         2:  t = 34'sd167458907;
         3:  t = 34'sd85004756;
         4:  t = 34'sd42667331;
         5:  t = 34'sd21354465;
         6:  t = 34'sd10679838;
         7:  t = 34'sd5340245;
         8:  t = 34'sd2670163;
         9:  t = 34'sd1335087;
         10: t = 34'sd667544;
         11: t = 34'sd333772;
         12: t = 34'sd166886;
         13: t = 34'sd83443;
         14: t = 34'sd41722;
         15: t = 34'sd20861;
         16: t = 34'sd10430;
         17: t = 34'sd5215;
         18: t = 34'sd2608;
         19: t = 34'sd1304;
         20: t = 34'sd652;
         21: t = 34'sd326;
         22: t = 34'sd163;
         23: t = 34'sd81;
         24: t = 34'sd41;
         25: t = 34'sd20;
         26: t = 34'sd10;
         27: t = 34'sd5;
         28: t = 34'sd3;
         29: t = 34'sd1;
         30: t = 34'sd1;
         default: t = 34'sd0;
      endcase
      return t;
   endfunction

endpackage

[design/ertm_if.sv]
// ----------------------------------------------------------------------------
// ertm_req_if / ertm_rsp_if
// valid/ready channels carrying angles in and matrix words out
// ----------------------------------------------------------------------------
interface ertm_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] heading;
   logic [15:0] pitch;
   logic [15:0] roll;

   modport source (output valid, output heading, output pitch, output roll, input ready);
   modport sink   (input valid, input heading, input pitch, input roll, output ready);
endinterface

interface ertm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] row0_col0;
   logic signed [15:0] row0_col1;
   logic signed [15:0] row0_col2;
   logic signed [15:0] row1_col0;
   logic signed [15:0] row1_col1;
   logic signed [15:0] row1_col2;
   logic signed [15:0] row2_col0;
   logic signed [15:0] row2_col1;
   logic signed [15:0] row2_col2;

   modport source (output valid, output row0_col0, output row0_col1, output row0_col2,
                   output row1_col0, output row1_col1, output row1_col2,
                   output row2_col0, output row2_col1, output row2_col2, input ready);
   modport sink   (input valid, input row0_col0, input row0_col1, input row0_col2,
                   input row1_col0, input row1_col1, input row1_col2,
                   input row2_col0, input row2_col1, input row2_col2, output ready);
endinterface

[design/ertm_cordic.sv]
// ----------------------------------------------------------------------------
// ertm_cordic
// pipelined rotation-mode cordic: quadrant fold, one stage per iteration, unfold
// ----------------------------------------------------------------------------
module ertm_cordic
   import ertm_pkg::*;
(
   input  logic                   clock,
   input  logic [CORDIC_PIPE-1:0] stage_en,
   input  field_type              angle,
   output sincos_type             result
);

   val_type    x_ff    [CORDIC_N+1];
   val_type    y_ff    [CORDIC_N+1];
   val_type    z_ff    [CORDIC_N+1];
   logic       flip_ff [CORDIC_N+1];
   sincos_type res_ff;

   logic [31:0] ext;
   logic [31:0] a32;
   val_type     z_in;
   logic        flip_in;

   // fold into [-90, +90] degrees, remember to negate at the end
   always_comb begin
      ext     = 32'(angle);
      a32     = ext << (32 - ANGLE_BITS);
      z_in    = {{(VAL_W-32){a32[31]}}, a32};
      flip_in = 1'b0;
      if (z_in > QUARTER_TURN || z_in < -QUARTER_TURN) begin
         flip_in = 1'b1;
         z_in    = (z_in > 0) ? z_in - HALF_TURN : z_in + HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_in;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < CORDIC_N; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (stage_en[i+1]) begin
            flip_ff[i+1] <= flip_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_of(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_of(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[CORDIC_N+1]) begin
         res_ff.s <= flip_ff[CORDIC_N] ? -y_ff[CORDIC_N] : y_ff[CORDIC_N];
         res_ff.c <= flip_ff[CORDIC_N] ? -x_ff[CORDIC_N] : x_ff[CORDIC_N];
      end
   end

   assign result = res_ff;

endmodule

[design/ertm_products.sv]
// ----------------------------------------------------------------------------
// ertm_products
// multiply, round and clamp pipeline forming the nine matrix elements
// ----------------------------------------------------------------------------
module ertm_products
   import ertm_pkg::*;
(
   input  logic                           clock,
   input  logic [PROD_STAGES-1:0]         stage_en,
   input  sincos_type                     head,
   input  sincos_type                     pitch,
   input  sincos_type                     roll,
   output logic [NUM_ELEM-1:0][FIELD_W-1:0] elem
);

   localparam int OUT_SHIFT = 2 * WORK_FRAC - OUT_FRACTION_BITS;

   // stage a
   prod_type   m_sps_ff, m_spc_ff, a00_ff, a10_ff, a21_ff, a22_ff;
   sincos_type ah_ff, ar_ff;
   val_type    asp_ff;
   // stage b
   val_type    sps_ff, spc_ff;
   prod_type   b00_ff, b10_ff, b21_ff, b22_ff;
   sincos_type bh_ff, br_ff;
   val_type    bsp_ff;
   // stage c
   prod_type   t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff, t7_ff, t8_ff;
   prod_type   c00_ff, c10_ff, c21_ff, c22_ff;
   val_type    csp_ff;
   // stage d
   prod_type   q_ff [NUM_ELEM];
   // stage e
   logic [NUM_ELEM-1:0][FIELD_W-1:0] out_ff;

   function automatic val_type round_q30(input prod_type v);
      prod_type t;
      t = (v + (prod_type'(1) <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
      return t[VAL_W-1:0];
   endfunction

   function automatic field_type to_out(input prod_type v);
      prod_type t;
      prod_type one;
      one = prod_type'(1) <<< OUT_FRACTION_BITS;
      t   = (v + (prod_type'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      if (t > one)  t = one;
      if (t < -one) t = -one;
      return t[FIELD_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         m_sps_ff <= pitch.s * roll.s;
         m_spc_ff <= pitch.s * roll.c;
         a00_ff   <= head.c * pitch.c;
         a10_ff   <= head.s * pitch.c;
         a21_ff   <= pitch.c * roll.s;
         a22_ff   <= pitch.c * roll.c;
         ah_ff    <= head;
         ar_ff    <= roll;
         asp_ff   <= pitch.s;
      end
      if (stage_en[1]) begin
         sps_ff <= round_q30(m_sps_ff);
         spc_ff <= round_q30(m_spc_ff);
         b00_ff <= a00_ff;
         b10_ff <= a10_ff;
         b21_ff <= a21_ff;
         b22_ff <= a22_ff;
         bh_ff  <= ah_ff;
         br_ff  <= ar_ff;
         bsp_ff <= asp_ff;
      end
      if (stage_en[2]) begin
         t1_ff  <= bh_ff.c * sps_ff;
         t2_ff  <= bh_ff.s * br_ff.c;
         t3_ff  <= bh_ff.c * spc_ff;
         t4_ff  <= bh_ff.s * br_ff.s;
         t5_ff  <= bh_ff.s * sps_ff;
         t6_ff  <= bh_ff.c * br_ff.c;
         t7_ff  <= bh_ff.s * spc_ff;
         t8_ff  <= bh_ff.c * br_ff.s;
         c00_ff <= b00_ff;
         c10_ff <= b10_ff;
         c21_ff <= b21_ff;
         c22_ff <= b22_ff;
         csp_ff <= bsp_ff;
      end
      if (stage_en[3]) begin
         q_ff[0] <= c00_ff;
         q_ff[1] <= t1_ff - t2_ff;
         q_ff[2] <= t3_ff + t4_ff;
         q_ff[3] <= c10_ff;
         q_ff[4] <= t5_ff + t6_ff;
         q_ff[5] <= t7_ff - t8_ff;
         q_ff[6] <= -(prod_type'(csp_ff) <<< WORK_FRAC);
         q_ff[7] <= c21_ff;
         q_ff[8] <= c22_ff;
      end
      if (stage_en[4]) begin
         for (int k = 0; k < NUM_ELEM; k++) begin
            out_ff[k] <= to_out(q_ff[k]);
         end
      end
   end

   assign elem = out_ff;

endmodule

[design/euler_to_rotation_matrix_unit.sv]
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_unit
// zyx euler angles (binary angle units) to a Q2.14 rotation matrix
// ----------------------------------------------------------------------------
// usage
//  - req channel: one word of heading, pitch, roll per handshake, each 16-bit
//    binary angle (full turn = 65536 units, wraps)
//  - rsp channel: one word of nine signed Q2.14 elements of Rz*Ry*Rx,
//    rounded to nearest and clamped to +-1.0
//  - pipeline from accept to rsp valid: fold stage, one stage per cordic
//    iteration, unfold stage, then five stages of multiply / round /
//    multiply / sum / round-and-clamp
//  - throughput: one word per cycle unless rsp_chan stalls; all three angles run in parallel cordics
//  - every stage carries its own valid bit; a stage loads whenever it is
//    empty or the stage after it moves, so bubbles are squeezed out and
//    req_chan stays ready while rsp_chan is stalled until the pipe is full
//  - a stalled result holds steady on rsp_chan until taken
//  - reset (synchronous) clears the valid bits only; data registers keep their values and no other state exists
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_unit
   import ertm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ertm_req_if.sink    req_chan,
   ertm_rsp_if.source  rsp_chan
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] stage_en;

   sincos_type sc_head, sc_pitch, sc_roll;
   logic [NUM_ELEM-1:0][FIELD_W-1:0] elem;

   // per-stage advance, computed back from the output
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   // valid bits follow the data
   always_comb begin
      valid_in[0] = stage_en[0] ? req_chan.valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = stage_en[0];

   // three cordics share the same stage enables
   ertm_cordic u_cordic_head (
      .clock    (clock),
      .stage_en (stage_en[CORDIC_PIPE-1:0]),
      .angle    (req_chan.heading),
      .result   (sc_head)
   );

   ertm_cordic u_cordic_pitch (
      .clock    (clock),
      .stage_en (stage_en[CORDIC_PIPE-1:0]),
      .angle    (req_chan.pitch),
      .result   (sc_pitch)
   );

   ertm_cordic u_cordic_roll (
      .clock    (clock),
      .stage_en (stage_en[CORDIC_PIPE-1:0]),
      .angle    (req_chan.roll),
      .result   (sc_roll)
   );

   ertm_products u_products (
      .clock    (clock),
      .stage_en (stage_en[NUM_STAGES-1:CORDIC_PIPE]),
      .head     (sc_head),
      .pitch    (sc_pitch),
      .roll     (sc_roll),
      .elem     (elem)
   );

   // output word straight from the last stage register
   assign rsp_chan.valid     = valid_ff[NUM_STAGES-1];
   assign rsp_chan.row0_col0 = elem[0];
   assign rsp_chan.row0_col1 = elem[1];
   assign rsp_chan.row0_col2 = elem[2];
   assign rsp_chan.row1_col0 = elem[3];
   assign rsp_chan.row1_col1 = elem[4];
   assign rsp_chan.row1_col2 = elem[5];
   assign rsp_chan.row2_col0 = elem[6];
   assign rsp_chan.row2_col1 = elem[7];
   assign rsp_chan.row2_col2 = elem[8];

endmodule

[sim/ertm_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ertm_tb_if
// holds no channel interfaces; those the testbench binds to come from the
// design's own interface file, so this file only carries the shared test types
// ----------------------------------------------------------------------------
package ertm_tb_pkg;

   // one angle word as the testbench drives it
   typedef struct packed {
      logic [15:0] heading;
      logic [15:0] pitch;
      logic [15:0] roll;
   } angles_type;

   // one matrix word, row major
   typedef struct packed {
      logic [15:0] m00;
      logic [15:0] m01;
      logic [15:0] m02;
      logic [15:0] m10;
      logic [15:0] m11;
      logic [15:0] m12;
      logic [15:0] m20;
      logic [15:0] m21;
      logic [15:0] m22;
   } matrix_type;

endpackage

[sim/tb_euler_to_rotation_matrix_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_to_rotation_matrix_unit
// drives heading/pitch/roll words through the unit and checks every matrix
// word against a bit-exact cordic/fixed-point model kept here, or a typed value
// ----------------------------------------------------------------------------
module tb_euler_to_rotation_matrix_unit
   import ertm_pkg::*;
   import ertm_tb_pkg::*;
();

   localparam int N_RANDOM    = 800;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 40;

   logic clock;
   logic reset;

   ertm_req_if req_chan ();
   ertm_rsp_if rsp_chan ();

   euler_to_rotation_matrix_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // matrix predictor
   // ---------------------------------------------------------------------
   // atan(2^-i) in 2^-32 turn units
   function automatic longint arctan_step(input int i);
      longint t [32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                         21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                         333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                         1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
      return t[i];
   endfunction

   // round to nearest, ties up; >>> on longint is a floor shift
   function automatic longint round_shift(input longint v, input int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   // sine and cosine of a binary angle in Q1.30
   function automatic void angle_sin_cos(input logic [15:0] ang, output longint s,
                                         output longint c);
      longint z, x, y, dx, dy;
      bit     flip;
      z = longint'({ang, 16'h0000});
      x = 652032874;
      y = 0;
      flip = 0;
      if (z >= 64'sd2147483648) z -= 64'sd4294967296;
      // fold the outer half circle onto the inner one
      if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
         z += (z > 0) ? -64'sd2147483648 : 64'sd2147483648;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_N; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_step(i);
         end else begin
            x += dx; y -= dy; z += arctan_step(i);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      s = y;
      c = x;
   endfunction

   // Q60 to clamped output field
   function automatic logic [15:0] q60_to_field(input longint v);
      longint one, r;
      one = 64'sd1 <<< OUT_FRACTION_BITS;
      r = round_shift(v, 2 * WORK_FRAC - OUT_FRACTION_BITS);
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[15:0];
   endfunction

   function automatic matrix_type rotation_of(input angles_type a);
      longint sh, ch, sp, cp, sr, cr, spsr, spcr;
      matrix_type m;
      angle_sin_cos(a.heading, sh, ch);
      angle_sin_cos(a.pitch, sp, cp);
      angle_sin_cos(a.roll, sr, cr);
      spsr = round_shift(sp * sr, WORK_FRAC);
      spcr = round_shift(sp * cr, WORK_FRAC);
      m.m00 = q60_to_field(ch * cp);
      m.m01 = q60_to_field(ch * spsr - sh * cr);
      m.m02 = q60_to_field(ch * spcr + sh * sr);
      m.m10 = q60_to_field(sh * cp);
      m.m11 = q60_to_field(sh * spsr + ch * cr);
      m.m12 = q60_to_field(sh * spcr - ch * sr);
      m.m20 = q60_to_field(-sp * (64'sd1 <<< WORK_FRAC));
      m.m21 = q60_to_field(cp * sr);
      m.m22 = q60_to_field(cp * cr);
      return m;
   endfunction

   // ---------------------------------------------------------------------
   // directed table; typed rows check that value instead of the model; other rows use the model too
   // ---------------------------------------------------------------------
   typedef struct {
      angles_type ang;
      bit         typed;
      matrix_type want;
   } table_row_type;

   localparam logic [15:0] ONE  = 16'sd16384;
   localparam logic [15:0] ZERO = 16'd0;

   table_row_type stim_table [] = '{
      // all zero angles: identity
      '{'{16'h0000, 16'h0000, 16'h0000}, 1,
        '{ONE, ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE}},
      // all ones in every field
      '{'{16'hffff, 16'hffff, 16'hffff}, 0, '0},
      '{'{16'h4000, 16'h0000, 16'h0000}, 0, '0},
      '{'{16'h8000, 16'h0000, 16'h0000}, 0, '0},
      '{'{16'hc000, 16'h0000, 16'h0000}, 0, '0},
      // pitch at the quarter turns, where sin saturates and clamping matters, and at the half turn
      '{'{16'h0000, 16'h4000, 16'h0000}, 0, '0},
      '{'{16'h0000, 16'hc000, 16'h0000}, 0, '0},
      '{'{16'h0000, 16'h8000, 16'h0000}, 0, '0},
      '{'{16'h0000, 16'h0000, 16'h4000}, 0, '0},
      '{'{16'h0000, 16'h0000, 16'h8000}, 0, '0},
      // fold boundary just either side of a quarter turn and of the half turn
      '{'{16'h3fff, 16'h4001, 16'hbfff}, 0, '0},
      '{'{16'hc001, 16'h7fff, 16'h8001}, 0, '0},
      '{'{16'h0001, 16'h0001, 16'h0001}, 0, '0},
      '{'{16'h2000, 16'h2000, 16'h2000}, 0, '0},
      '{'{16'h5555, 16'haaaa, 16'h5555}, 0, '0},
      '{'{16'haaaa, 16'h5555, 16'haaaa}, 0, '0},
      '{'{16'h8000, 16'h8000, 16'h8000}, 0, '0},
      '{'{16'h7fff, 16'h7fff, 16'h7fff}, 0, '0}
   };

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------
   matrix_type expected_q [$];
   int      n_sent, n_taken, n_errors, cycles;
   bit      quiet_tail;   // last part of the run has no idling
   bit      send_done;

   task automatic send_word(input angles_type a);
      int gap;
      // random idle burst ahead of the word
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.heading <= a.heading;
      req_chan.pitch   <= a.pitch;
      req_chan.roll    <= a.roll;
      do @(posedge clock); while (!req_chan.ready);
      // accepted at this edge
      expected_q.push_back(rotation_of(a));
      n_sent++;
   endtask

   function automatic logic [15:0] random_angle();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'(16'h4000 + $urandom_range(0, 6) - 3);   // near quarter turn
         3: return 16'(16'hc000 + $urandom_range(0, 6) - 3);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      angles_type a;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.heading = '0;
      req_chan.pitch   = '0;
      req_chan.roll    = '0;
      quiet_tail       = 0;
      send_done        = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i]) begin
         send_word(stim_table[i].ang);
         if (stim_table[i].typed) expected_q[$] = stim_table[i].want;
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i >= N_RANDOM - N_RANDOM / 8) quiet_tail = 1;
         a.heading = random_angle();
         a.pitch   = random_angle();
         a.roll    = random_angle();
         send_word(a);
      end
      req_chan.valid <= 1'b0;
      send_done = 1;
   end

   // ---------------------------------------------------------------------
   // response side: random stall bursts, then field-by-field compare
   // ---------------------------------------------------------------------
   int stall_left;

   initial begin
      rsp_chan.ready = 1'b0;
      stall_left     = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         n_errors++;
      end
   endtask

   always @(posedge clock) begin
      matrix_type w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_q.size() == 0) begin
            $error("matrix word with no angles outstanding");
            n_errors++;
         end else begin
            w = expected_q.pop_front();
            check_field("row0_col0", w.m00, rsp_chan.row0_col0);
            check_field("row0_col1", w.m01, rsp_chan.row0_col1);
            check_field("row0_col2", w.m02, rsp_chan.row0_col2);
            check_field("row1_col0", w.m10, rsp_chan.row1_col0);
            check_field("row1_col1", w.m11, rsp_chan.row1_col1);
            check_field("row1_col2", w.m12, rsp_chan.row1_col2);
            check_field("row2_col0", w.m20, rsp_chan.row2_col0);
            check_field("row2_col1", w.m21, rsp_chan.row2_col1);
            check_field("row2_col2", w.m22, rsp_chan.row2_col2);
         end
         n_taken++;
      end
   end

   // ---------------------------------------------------------------------
   // end of run and watchdog
   // ---------------------------------------------------------------------
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, expected_q.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      n_errors = 0;
      n_sent   = 0;
      n_taken  = 0;
      wait (send_done);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("sent %0d angle words (%0d directed), took %0d matrix words",
               n_sent, stim_table.size(), n_taken);
      $display("mismatches: %0d", n_errors);
      if (n_errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
